>>> src/assert_macros.svh
// Assertion helpers for the taint range table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/trt_pkg.sv
`default_nettype none
package trt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ADDR_W = 64;
    localparam int LEN_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

    // request kinds
    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // cell operations
    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_LOOK = 3'd1;
    localparam logic [2:0] OP_TRIM = 3'd2;
    localparam logic [2:0] OP_DROP = 3'd3;
    localparam logic [2:0] OP_INS  = 3'd4;

    // cell reset contents
    localparam int CELL_EMPTY  = 0;
    localparam int CELL_BOTTOM = 1;
    localparam int CELL_TOP    = 2;

    typedef struct packed {
        logic [2:0]        op;
        logic              shift;
        logic              wr_end;
        logic [ADDR_W-1:0] end_val;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] e;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] val;
    } ctrl_t;

endpackage
`default_nettype wire

>>> src/trt_cell.sv
`default_nettype none
module trt_cell #(
    parameter int RESET_KIND = trt_pkg::CELL_EMPTY
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire trt_pkg::ctrl_t              ctrl,
    input  wire logic                        left_le,
    input  wire logic                        left_gt,
    input  wire logic [trt_pkg::ADDR_W-1:0]  left_start,
    input  wire logic [trt_pkg::ADDR_W-1:0]  left_end,
    input  wire logic                        left_valid,
    input  wire logic                        right_le,
    input  wire logic [trt_pkg::ADDR_W-1:0]  right_start,
    input  wire logic [trt_pkg::ADDR_W-1:0]  right_end,
    input  wire logic                        right_valid,
    output logic [trt_pkg::ADDR_W-1:0]       ent_start,
    output logic [trt_pkg::ADDR_W-1:0]       ent_end,
    output logic                             ent_valid,
    output logic                             le,
    output logic                             gt,
    output logic                             is_p,
    output logic                             is_n,
    output logic                             eq_hit
);
    import trt_pkg::*;

    localparam logic RST_VALID = (RESET_KIND != CELL_EMPTY);
    localparam logic [ADDR_W-1:0] RST_WORD = (RESET_KIND == CELL_TOP) ? ADDR_TOP : '0;

    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic              valid_reg, valid_next;
    logic              le_reg, le_next;

    assign ent_start = start_reg;
    assign ent_end   = end_reg;
    assign ent_valid = valid_reg;
    assign le        = le_reg;
    assign gt        = !valid_reg || (start_reg > ctrl.key);
    assign is_p      = le_reg && !right_le;
    assign is_n      = valid_reg && !le_reg && left_le;
    assign eq_hit    = valid_reg && (start_reg == ctrl.e);

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        valid_next = valid_reg;
        le_next    = le_reg;
        unique case (ctrl.op)
            OP_LOOK:
            begin
                le_next = valid_reg && (start_reg <= ctrl.a);
            end
            OP_TRIM:
            begin
                if (ctrl.shift && !le_reg)
                begin
                    start_next = right_start;
                    end_next   = right_end;
                    valid_next = right_valid;
                end
                else if (ctrl.wr_end && is_p)
                begin
                    end_next = ctrl.end_val;
                end
            end
            OP_DROP:
            begin
                if (!le_reg || is_p)
                begin
                    start_next = right_start;
                    end_next   = right_end;
                    valid_next = right_valid;
                end
            end
            OP_INS:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        start_next = left_start;
                        end_next   = left_end;
                        valid_next = left_valid;
                    end
                    else
                    begin
                        start_next = ctrl.key;
                        end_next   = ctrl.val;
                        valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= RST_WORD;
            end_reg   <= RST_WORD;
            valid_reg <= RST_VALID;
            le_reg    <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            valid_reg <= valid_next;
            le_reg    <= le_next;
        end
    end

endmodule
`default_nettype wire

>>> src/taint_range_table_unit.sv
// Taint range table: a sorted set of half-open tainted address ranges.
// Input channel (in_valid / in_stall) carries one request word: req_type
// (query, set, clear), range_start and range_length. The range end is
// start + length, saturated at the top of the address space.
// Output channel (out_valid / out_stall) carries one result word per
// request: taint_hit for a query, table_full when a set or clear needed
// a new entry while the table was full (the request is then dropped).
// One request is worked on at a time. From acceptance to its result a
// request passes through broadcast compare across the cell chain,
// decode of the covering and next entries, then one chain step each for
// trim, drop, insert and bottom re-insert, then the load of the result.
// The next request is taken the cycle after the result is loaded into the
// output register; no new request is taken while one is in progress.
// When the output register is still full and the sink stalls, the
// finished result waits in the done state and in_stall stays high.
// Reset (rst_n low, asynchronous) leaves the table with the bottom
// entry (0,0) and the top entry (all ones, all ones), and clears
// out_valid.
`default_nettype none
`include "assert_macros.svh"
module taint_range_table_unit #(
    parameter int TABLE_DEPTH = trt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 req_type,
    input  wire logic [trt_pkg::ADDR_W-1:0] range_start,
    input  wire logic [trt_pkg::LEN_W-1:0]  range_length,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            taint_hit,
    output logic                            table_full
);
    import trt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_PLAN = 3'd2;
    localparam logic [2:0] ST_TRIM = 3'd3;
    localparam logic [2:0] ST_DROP = 3'd4;
    localparam logic [2:0] ST_INS  = 3'd5;
    localparam logic [2:0] ST_INS0 = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] a_reg;
    logic [ADDR_W-1:0] e_reg;
    logic              eq_e_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              out_valid_reg;
    logic              taint_out_reg;
    logic              full_out_reg;

    // decoded plan for the request
    logic              plan_wr_end_reg, plan_drop_n_reg, plan_drop_p_reg;
    logic              plan_ins_reg, plan_ins0_reg, plan_full_reg, plan_taint_reg;
    logic [ADDR_W-1:0] plan_end_val_reg, plan_key_reg, plan_val_reg;
    logic              plan_wr_end, plan_drop_n, plan_drop_p;
    logic              plan_ins, plan_ins0, plan_full, plan_taint;
    logic [ADDR_W-1:0] plan_end_val, plan_key, plan_val;

    ctrl_t ctrl;

    logic [ADDR_W-1:0] c_start [TABLE_DEPTH];
    logic [ADDR_W-1:0] c_end   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] c_valid, c_le, c_gt, c_is_p, c_is_n, c_eq;

    logic              accept_in;
    logic [ADDR_W:0]   sum_full;
    logic [ADDR_W-1:0] e_in;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign taint_hit  = taint_out_reg;
    assign table_full = full_out_reg;

    assign sum_full = {1'b0, range_start} + {{(ADDR_W + 1 - LEN_W){1'b0}}, range_length};
    assign e_in     = sum_full[ADDR_W] ? ADDR_TOP : sum_full[ADDR_W-1:0];

    // cell chain
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            localparam int KIND = (g == 0) ? CELL_BOTTOM : ((g == 1) ? CELL_TOP : CELL_EMPTY);
            if (g == 0)
            begin : g_first
                trt_cell #(.RESET_KIND(KIND)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .left_le     (1'b0),
                    .left_gt     (1'b0),
                    .left_start  ('0),
                    .left_end    ('0),
                    .left_valid  (1'b0),
                    .right_le    (c_le[g+1]),
                    .right_start (c_start[g+1]),
                    .right_end   (c_end[g+1]),
                    .right_valid (c_valid[g+1]),
                    .ent_start   (c_start[g]),
                    .ent_end     (c_end[g]),
                    .ent_valid   (c_valid[g]),
                    .le          (c_le[g]),
                    .gt          (c_gt[g]),
                    .is_p        (c_is_p[g]),
                    .is_n        (c_is_n[g]),
                    .eq_hit      (c_eq[g])
                );
            end
            else if (g == TABLE_DEPTH - 1)
            begin : g_last
                trt_cell #(.RESET_KIND(KIND)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .left_le     (c_le[g-1]),
                    .left_gt     (c_gt[g-1]),
                    .left_start  (c_start[g-1]),
                    .left_end    (c_end[g-1]),
                    .left_valid  (c_valid[g-1]),
                    .right_le    (1'b0),
                    .right_start ('0),
                    .right_end   ('0),
                    .right_valid (1'b0),
                    .ent_start   (c_start[g]),
                    .ent_end     (c_end[g]),
                    .ent_valid   (c_valid[g]),
                    .le          (c_le[g]),
                    .gt          (c_gt[g]),
                    .is_p        (c_is_p[g]),
                    .is_n        (c_is_n[g]),
                    .eq_hit      (c_eq[g])
                );
            end
            else
            begin : g_mid
                trt_cell #(.RESET_KIND(KIND)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .left_le     (c_le[g-1]),
                    .left_gt     (c_gt[g-1]),
                    .left_start  (c_start[g-1]),
                    .left_end    (c_end[g-1]),
                    .left_valid  (c_valid[g-1]),
                    .right_le    (c_le[g+1]),
                    .right_start (c_start[g+1]),
                    .right_end   (c_end[g+1]),
                    .right_valid (c_valid[g+1]),
                    .ent_start   (c_start[g]),
                    .ent_end     (c_end[g]),
                    .ent_valid   (c_valid[g]),
                    .le          (c_le[g]),
                    .gt          (c_gt[g]),
                    .is_p        (c_is_p[g]),
                    .is_n        (c_is_n[g]),
                    .eq_hit      (c_eq[g])
                );
            end
        end
    endgenerate

    // gather covering (p) and next (n) entries, then decode the request
    always_comb
    begin
        logic [ADDR_W-1:0] ps, pe, ns_raw, ne_raw, ns, ne;
        logic              nx, exist;
        logic [CNT_W:0]    c1, c2;
        ps = '0;
        pe = '0;
        ns_raw = '0;
        ne_raw = '0;
        nx = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            ps     = ps | ({ADDR_W{c_is_p[j]}} & c_start[j]);
            pe     = pe | ({ADDR_W{c_is_p[j]}} & c_end[j]);
            ns_raw = ns_raw | ({ADDR_W{c_is_n[j]}} & c_start[j]);
            ne_raw = ne_raw | ({ADDR_W{c_is_n[j]}} & c_end[j]);
            nx     = nx | c_is_n[j];
        end
        ns = nx ? ns_raw : ADDR_TOP;
        ne = nx ? ne_raw : ADDR_TOP;

        plan_wr_end  = 1'b0;
        plan_end_val = '0;
        plan_drop_n  = 1'b0;
        plan_drop_p  = 1'b0;
        plan_ins     = 1'b0;
        plan_key     = '0;
        plan_val     = '0;
        plan_ins0    = 1'b0;
        plan_taint   = 1'b0;
        exist        = 1'b0;

        if (kind_reg == REQ_QUERY)
        begin
            plan_taint = (pe > a_reg) || (nx && (ns < e_reg));
        end
        else if (kind_reg == REQ_SET)
        begin
            plan_key = a_reg;
            exist    = (a_reg == ps);
            if (e_reg <= pe)
            begin
            end
            else if (a_reg <= pe)
            begin
                plan_wr_end = 1'b1;
                if (e_reg < ns)
                begin
                    plan_end_val = e_reg;
                end
                else if (e_reg <= ne)
                begin
                    plan_end_val = ne;
                    plan_drop_n  = nx;
                end
                else
                begin
                    plan_end_val = e_reg;
                    plan_drop_n  = nx;
                end
            end
            else
            begin
                plan_ins = 1'b1;
                if (e_reg < ns)
                begin
                    plan_val = e_reg;
                end
                else if (e_reg <= ne)
                begin
                    plan_drop_n = nx;
                    plan_val    = ne;
                end
                else
                begin
                    plan_drop_n = nx;
                    plan_val    = e_reg;
                end
            end
        end
        else if (kind_reg == REQ_CLEAR)
        begin
            plan_key = e_reg;
            if (a_reg == ps)
            begin
                plan_drop_p = 1'b1;
                if (e_reg < pe)
                begin
                    plan_ins = 1'b1;
                    plan_val = pe;
                end
                else if (e_reg <= ns)
                begin
                end
                else if (e_reg < ne)
                begin
                    plan_drop_n = nx;
                    plan_ins    = 1'b1;
                    plan_val    = ne;
                end
                else
                begin
                    plan_drop_n = nx;
                end
            end
            else if (e_reg < pe)
            begin
                plan_wr_end  = 1'b1;
                plan_end_val = a_reg;
                plan_ins     = 1'b1;
                plan_val     = pe;
            end
            else
            begin
                plan_wr_end  = (a_reg < pe);
                plan_end_val = a_reg;
                if (e_reg <= ns)
                begin
                end
                else if (e_reg < ne)
                begin
                    plan_drop_n = nx;
                    plan_ins    = 1'b1;
                    plan_val    = ne;
                end
                else
                begin
                    plan_drop_n = nx;
                end
            end
            exist = eq_e_reg && !(plan_drop_p && (e_reg == ps))
                    && !(plan_drop_n && (e_reg == ns));
        end

        plan_ins  = plan_ins && !exist;
        plan_ins0 = (kind_reg == REQ_CLEAR) && plan_drop_p && c_is_p[0]
                    && !(plan_ins && (e_reg == '0));
        c1 = {1'b0, count_reg} - {{CNT_W{1'b0}}, plan_drop_n}
             - {{CNT_W{1'b0}}, plan_drop_p};
        c2 = c1 + {{CNT_W{1'b0}}, plan_ins};
        plan_full = (plan_ins && (c1 >= DEPTH_C)) || (plan_ins0 && (c2 >= DEPTH_C));
    end

    // drive the chain for the current step
    always_comb
    begin
        ctrl.op      = OP_HOLD;
        ctrl.shift   = plan_drop_n_reg;
        ctrl.wr_end  = plan_wr_end_reg;
        ctrl.end_val = plan_end_val_reg;
        ctrl.a       = a_reg;
        ctrl.e       = e_reg;
        ctrl.key     = (state_reg == ST_INS0) ? '0 : plan_key_reg;
        ctrl.val     = (state_reg == ST_INS0) ? '0 : plan_val_reg;
        count_next   = count_reg;
        unique case (state_reg)
            ST_LOOK:
            begin
                ctrl.op = OP_LOOK;
            end
            ST_TRIM:
            begin
                if (!plan_full_reg && (plan_drop_n_reg || plan_wr_end_reg))
                begin
                    ctrl.op = OP_TRIM;
                end
                if (!plan_full_reg && plan_drop_n_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_DROP:
            begin
                if (!plan_full_reg && plan_drop_p_reg)
                begin
                    ctrl.op    = OP_DROP;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_INS:
            begin
                if (!plan_full_reg && plan_ins_reg)
                begin
                    ctrl.op    = OP_INS;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_INS0:
            begin
                if (!plan_full_reg && plan_ins0_reg)
                begin
                    ctrl.op    = OP_INS;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept_in) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_PLAN;
            ST_PLAN: state_next = ST_TRIM;
            ST_TRIM: state_next = ST_DROP;
            ST_DROP: state_next = ST_INS;
            ST_INS:  state_next = ST_INS0;
            ST_INS0: state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            // hold the result word until the sink takes it
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            kind_reg <= req_type;
            a_reg    <= range_start;
            e_reg    <= e_in;
        end
        if (state_reg == ST_LOOK)
        begin
            eq_e_reg <= |c_eq;
        end
        if (state_reg == ST_PLAN)
        begin
            plan_wr_end_reg  <= plan_wr_end;
            plan_end_val_reg <= plan_end_val;
            plan_drop_n_reg  <= plan_drop_n;
            plan_drop_p_reg  <= plan_drop_p;
            plan_ins_reg     <= plan_ins;
            plan_key_reg     <= plan_key;
            plan_val_reg     <= plan_val;
            plan_ins0_reg    <= plan_ins0;
            plan_full_reg    <= plan_full;
            plan_taint_reg   <= plan_taint;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            taint_out_reg <= plan_taint_reg;
            full_out_reg  <= plan_full_reg;
        end
    end

    `TRT_ASSERT_NEXT(a_accept_look, clk, rst_n, accept_in, state_reg == ST_LOOK, "accepted word did not start a lookup")
    `TRT_ASSERT_NOW(a_count_range, clk, rst_n, state_reg == ST_IDLE, (count_reg >= CNT_W'(1)) && (count_reg <= DEPTH_C[CNT_W-1:0]), "entry count out of range")
    `TRT_ASSERT_NOW(a_count_match, clk, rst_n, state_reg == ST_IDLE, $countones(c_valid) == int'(count_reg), "entry count disagrees with cell valid bits")
    `TRT_ASSERT_NOW(a_bottom_entry, clk, rst_n, state_reg == ST_IDLE, c_valid[0] && (c_start[0] == '0), "bottom entry missing")
    `TRT_ASSERT_NOW(a_full_kind, clk, rst_n, (state_reg == ST_DONE) && plan_full_reg, (kind_reg == REQ_SET) || (kind_reg == REQ_CLEAR), "full flag on a request that stores nothing")

endmodule
`default_nettype wire
